// ----- design/bcs_pkg.sv -----
// Shared types, constants and the binomial table for the Bezier curve sampler.
// No dependencies.
`default_nettype none
package bcs_pkg;
    localparam int unsigned ONE_Q16 = 65536;
    localparam logic [0:0] OP_LOAD   = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;
    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [1:0] REG_T_STEP       = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic pow_step;
        logic basis_step;
        logic mac_step;
        logic finish;
    } bcs_cmd_t;

    // Binomial coefficient C(n,i) for n and i below eight.
    function automatic logic [5:0] binom(input logic [2:0] n, input logic [2:0] i);
        logic [5:0] r;
        r = 6'd1;
        if (i > n) begin
            r = 6'd0;
        end else begin
            // Rows of Pascal's triangle; the edges of each row are one.
            unique case ({n, i})
                {3'd2, 3'd1}: r = 6'd2;
                {3'd3, 3'd1}, {3'd3, 3'd2}: r = 6'd3;
                {3'd4, 3'd1}, {3'd4, 3'd3}: r = 6'd4;
                {3'd4, 3'd2}: r = 6'd6;
                {3'd5, 3'd1}, {3'd5, 3'd4}: r = 6'd5;
                {3'd5, 3'd2}, {3'd5, 3'd3}: r = 6'd10;
                {3'd6, 3'd1}, {3'd6, 3'd5}: r = 6'd6;
                {3'd6, 3'd2}, {3'd6, 3'd4}: r = 6'd15;
                {3'd6, 3'd3}: r = 6'd20;
                {3'd7, 3'd1}, {3'd7, 3'd6}: r = 6'd7;
                {3'd7, 3'd2}, {3'd7, 3'd5}: r = 6'd21;
                {3'd7, 3'd3}, {3'd7, 3'd4}: r = 6'd35;
                default: r = 6'd1;
            endcase
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- design/bcs_datapath.sv -----
// Datapath of the Bezier curve sampler: control point store, power tables,
// three Q1.16 multipliers and two multiply-accumulate lanes. Uses bcs_pkg.
`default_nettype none
module bcs_datapath #(
    parameter int MAX_CONTROL_POINTS = 4,
    parameter int IW = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire  bcs_pkg::bcs_cmd_t cmd,
    input  wire  [IW-1:0]         step_idx,
    input  wire  [2:0]            degree,
    input  wire  [16:0]           t_val,
    input  wire  [1:0]            load_idx,
    input  wire  [31:0]           load_x,
    input  wire  [31:0]           load_y,
    output logic [31:0]           res_x,
    output logic [31:0]           res_y
);
    import bcs_pkg::*;

    logic signed [31:0] px_reg [MAX_CONTROL_POINTS];
    logic signed [31:0] py_reg [MAX_CONTROL_POINTS];
    logic [16:0] tpow_reg [MAX_CONTROL_POINTS];
    logic [16:0] upow_reg [MAX_CONTROL_POINTS];
    logic [16:0] u_val;
    logic [22:0] basis_reg;
    logic signed [63:0] acc_x_reg, acc_y_reg;
    logic [16:0] tp_next, up_next, b_raw;
    logic [33:0] tprod, uprod, bprod;
    logic [IW-1:0] prev_idx, comp_idx;
    logic [2:0] wide_idx;
    logic signed [23:0] basis_s;
    logic signed [31:0] px_sel, py_sel;
    logic signed [55:0] term_x, term_y;

    assign u_val    = 17'(ONE_Q16) - t_val;
    assign prev_idx = step_idx - IW'(1);
    assign wide_idx = 3'(step_idx);
    assign comp_idx = IW'(degree - wide_idx);

    // Power step k: t^k = round(t^(k-1) * t), same for u.
    assign tprod   = tpow_reg[prev_idx] * t_val + 34'd32768;
    assign uprod   = upow_reg[prev_idx] * u_val + 34'd32768;
    assign tp_next = tprod[32:16];
    assign up_next = uprod[32:16];

    // Basis term round(t^i * u^(n-i)); all factors lie in [0, 1].
    assign bprod = tpow_reg[step_idx] * upow_reg[comp_idx] + 34'd32768;
    assign b_raw = bprod[32:16];

    // Signed products of the basis weight and the selected control point.
    assign basis_s = $signed({1'b0, basis_reg});
    assign px_sel  = px_reg[step_idx];
    assign py_sel  = py_reg[step_idx];
    assign term_x  = basis_s * px_sel;
    assign term_y  = basis_s * py_sel;

    // Control point store, cleared to zero by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_CONTROL_POINTS; k++) begin
                px_reg[k] <= '0;
                py_reg[k] <= '0;
            end
        end else if (cmd.load && (32'(load_idx) < MAX_CONTROL_POINTS)) begin
            px_reg[IW'(load_idx)] <= load_x;
            py_reg[IW'(load_idx)] <= load_y;
        end
    end

    // Power tables, basis weight and accumulators.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            tpow_reg[0] <= 17'(ONE_Q16);
            upow_reg[0] <= 17'(ONE_Q16);
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
        end
        if (cmd.pow_step) begin
            tpow_reg[step_idx] <= tp_next;
            upow_reg[step_idx] <= up_next;
        end
        if (cmd.basis_step) begin
            basis_reg <= 23'(b_raw) * 23'(binom(degree, wide_idx));
        end
        if (cmd.mac_step) begin
            acc_x_reg <= acc_x_reg + {{8{term_x[55]}}, term_x};
            acc_y_reg <= acc_y_reg + {{8{term_y[55]}}, term_y};
        end
    end

    // Round to Q16.16 with floor after bias, then saturate.
    function automatic logic [31:0] round_sat(input logic signed [63:0] a);
        logic signed [64:0] s;
        logic signed [48:0] v;
        s = 65'(a) + 65'sd32768;
        v = s[64:16];
        if (v > 49'sd2147483647) return 32'h7FFFFFFF;
        if (v < -49'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_x <= round_sat(acc_x_reg);
            res_y <= round_sat(acc_y_reg);
        end
    end
endmodule
`default_nettype wire

// ----- design/bcs_controller.sv -----
// Controller of the Bezier curve sampler: handshake, sweep state and the
// sequence of datapath steps. Uses bcs_pkg.
`default_nettype none
module bcs_controller #(
    parameter int MAX_CONTROL_POINTS = 4,
    parameter int MAX_SAMPLES = 1024,
    parameter int IW = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1,
    parameter int SW = $clog2(MAX_SAMPLES)
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire                     in_op,
    output logic                    out_valid,
    input  wire                     out_ready,
    input  wire  [2:0]              point_count,
    input  wire  [10:0]             sample_cnt_cfg,
    input  wire  [16:0]             t_step,
    output bcs_pkg::bcs_cmd_t       cmd,
    output logic [IW-1:0]           step_idx,
    output logic [2:0]              degree,
    output logic [16:0]             t_val,
    output logic [SW-1:0]           out_number,
    output logic                    out_last
);
    import bcs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POW   = 3'd1;
    localparam logic [2:0] S_BASIS = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [16:0] param_reg, t_reg;
    logic [SW-1:0] count_reg;
    logic [2:0] deg_reg;
    logic out_valid_reg, last_reg;
    logic [SW-1:0] num_reg;
    logic [3:0] pts;
    logic [12:0] smp;
    logic last_now;
    logic [17:0] param_sum;
    logic accept, final_idx;

    // Effective point and sample counts after clamping.
    always_comb begin
        pts = {1'b0, point_count};
        if (pts < 4'd1) pts = 4'd1;
        if (32'(pts) > MAX_CONTROL_POINTS) pts = 4'(MAX_CONTROL_POINTS);
        smp = {2'b0, sample_cnt_cfg};
        if (smp < 13'd2) smp = 13'd2;
        if (32'(smp) > MAX_SAMPLES) smp = 13'(MAX_SAMPLES);
    end

    assign last_now  = 13'(count_reg) >= smp - 13'd1;
    assign param_sum = 18'(param_reg) + 18'(t_step);
    assign in_ready  = (state_reg == S_IDLE) && !(out_valid_reg && !out_ready);
    assign accept    = in_valid && in_ready;
    assign final_idx = 3'(idx_reg) == deg_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        idx_next   = IW'(1);
                        state_next = (pts == 4'd1) ? S_BASIS : S_POW;
                        if (pts == 4'd1) idx_next = '0;
                    end
                end
            end
            S_POW: begin
                cmd.pow_step = 1'b1;
                if (final_idx) begin
                    idx_next   = '0;
                    state_next = S_BASIS;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_BASIS: begin
                cmd.basis_step = 1'b1;
                state_next     = S_MAC;
            end
            S_MAC: begin
                cmd.mac_step = 1'b1;
                if (final_idx) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_BASIS;
                end
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            param_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (cmd.finish) out_valid_reg <= 1'b1;
            if (accept) begin
                if (in_op == OP_LOAD || last_now) begin
                    param_reg <= '0;
                    count_reg <= '0;
                end else begin
                    param_reg <= (param_sum > 18'(ONE_Q16)) ? 17'(ONE_Q16) : param_sum[16:0];
                    count_reg <= count_reg + SW'(1);
                end
            end
        end
    end

    // Per-sample values latched at acceptance.
    always_ff @(posedge aclk) begin
        if (accept && in_op == OP_SAMPLE) begin
            t_reg    <= last_now ? 17'(ONE_Q16)
                      : ((param_reg > 17'(ONE_Q16)) ? 17'(ONE_Q16) : param_reg);
            deg_reg  <= 3'(pts - 4'd1);
            num_reg  <= count_reg;
            last_reg <= last_now;
        end
    end

    assign step_idx   = idx_reg;
    assign degree     = deg_reg;
    assign t_val      = t_reg;
    assign out_valid  = out_valid_reg;
    assign out_number = num_reg;
    assign out_last   = last_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg) else $error("result lost");
    a_param_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        param_reg <= 17'(ONE_Q16)) else $error("parameter above one");
endmodule
`default_nettype wire

// ----- design/bezier_curve_sampler_unit.sv -----
// Top level of the Bezier curve sampler: stream ports, configuration
// registers, controller and datapath. Uses bcs_pkg, bcs_controller, bcs_datapath.
//
// Usage: the s_ channel carries items. op 0 loads a control point and restarts
// the sweep, giving no result. op 1 produces one curve point on the m_ channel,
// with tlast set on the final sample of a sweep (taken at t equal to one).
// A sample with n = degree runs n power steps after it is accepted, then a basis
// step and a multiply-accumulate step for each control point, and a rounding step
// that loads the output register and raises m_tvalid. The next item is taken only
// once the controller has returned to idle, so a sample does not overlap the next
// item. A load writes its control point when it is accepted.
// The output register holds a finished result; a new item is accepted only
// once that register is free or being drained, so a stalled receiver stalls
// the input. Synchronous active-low reset clears the sweep, the output valid
// and the control points, and returns the configuration to its defaults.
`default_nettype none
module bezier_curve_sampler_unit #(
    parameter int MAX_CONTROL_POINTS = 4,
    parameter int MAX_SAMPLES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // point_x[31:0], point_y[63:32]
    input  wire  [2:0]  s_tuser,   // op[0], point_index[2:1]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // curve_x[31:0], curve_y[63:32], sample_number[73:64]
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [16:0] cfg_data
);
    import bcs_pkg::*;

    localparam int IW = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1;
    localparam int SW = $clog2(MAX_SAMPLES);

    logic [2:0]  pcount_reg;
    logic [10:0] scount_reg;
    logic [16:0] tstep_reg;
    bcs_cmd_t    cmd;
    logic [IW-1:0] step_idx;
    logic [2:0]  degree;
    logic [16:0] t_val;
    logic [31:0] rx, ry;
    logic [SW-1:0] num;
    logic [31:0] lx, ly;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= 3'd4;
            scount_reg <= 11'd2;
            tstep_reg  <= 17'(ONE_Q16);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POINT_COUNT:  pcount_reg <= cfg_data[2:0];
                REG_SAMPLE_COUNT: scount_reg <= cfg_data[10:0];
                REG_T_STEP:       tstep_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lx = s_tdata[31:0];
    assign ly = s_tdata[63:32];

    bcs_controller #(.MAX_CONTROL_POINTS(MAX_CONTROL_POINTS),
                     .MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser[0]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .point_count(pcount_reg), .sample_cnt_cfg(scount_reg), .t_step(tstep_reg),
        .cmd(cmd), .step_idx(step_idx), .degree(degree), .t_val(t_val),
        .out_number(num), .out_last(m_tlast)
    );

    bcs_datapath #(.MAX_CONTROL_POINTS(MAX_CONTROL_POINTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .step_idx(step_idx),
        .degree(degree), .t_val(t_val), .load_idx(s_tuser[2:1]),
        .load_x(lx), .load_y(ly),
        .res_x(rx), .res_y(ry)
    );

    assign m_tdata = {6'd0, 10'(num), ry, rx};
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for bezier_curve_sampler_unit: loads control points,
// sweeps curves under several configurations and checks every curve point.
// Depends on bcs_pkg and the RTL of the sampler.
`default_nettype none
module testbench;
    import bcs_pkg::*;

    typedef struct packed {
        logic [0:0]  op;
        logic [1:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } stream_item_t;

    typedef struct packed {
        logic [31:0] curve_x;
        logic [31:0] curve_y;
        logic [9:0]  sample_number;
        logic        last_sample;
    } curve_point_t;

    localparam int WATCHDOG_CYCLES = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    bezier_curve_sampler_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: configuration and the sampler's own state.
    logic [2:0]  pred_point_count;
    logic [10:0] pred_sample_count;
    logic [16:0] pred_t_step;
    logic signed [31:0] pred_ctrl_x [4];
    logic signed [31:0] pred_ctrl_y [4];
    logic [16:0] pred_param;
    logic [9:0]  pred_counter;

    stream_item_t pending_items[$];
    curve_point_t expected_points[$];
    int  failures;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    bit  stim_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] mul_q16(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + 64'd32768;
        return p[47:16];
    endfunction

    function automatic logic [31:0] round_saturate(input logic signed [63:0] acc);
        logic signed [63:0] v;
        v = (acc + 64'sd32768) >>> 16;
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic int binomial(input int n, input int i);
        int r;
        r = 1;
        for (int k = 1; k <= i; k++) r = r * (n - k + 1) / k;
        return r;
    endfunction

    // Applies one accepted item to the predictor and, for a sample, queues its curve point.
    task automatic predict_curve_point(input stream_item_t it);
        int points, samples, n;
        logic [31:0] t, u;
        logic [31:0] tpow [4];
        logic [31:0] upow [4];
        logic signed [63:0] acc_x, acc_y, basis;
        logic last;
        logic [31:0] nxt;
        curve_point_t cp;
        if (it.op == OP_LOAD) begin
            pred_ctrl_x[it.point_index] = it.point_x;
            pred_ctrl_y[it.point_index] = it.point_y;
            pred_param = '0;
            pred_counter = '0;
            return;
        end
        points = pred_point_count;
        if (points < 1) points = 1;
        if (points > 4) points = 4;
        samples = pred_sample_count;
        if (samples < 2) samples = 2;
        if (samples > 1024) samples = 1024;
        last = (int'(pred_counter) >= samples - 1);
        t = last ? ONE_Q16 : {15'd0, pred_param};
        if (t > ONE_Q16) t = ONE_Q16;
        u = ONE_Q16 - t;
        n = points - 1;
        tpow[0] = ONE_Q16;
        upow[0] = ONE_Q16;
        for (int k = 1; k <= n; k++) begin
            tpow[k] = mul_q16(tpow[k-1], t);
            upow[k] = mul_q16(upow[k-1], u);
        end
        acc_x = 0;
        acc_y = 0;
        for (int i = 0; i <= n; i++) begin
            basis = binomial(n, i) * $signed({32'd0, mul_q16(tpow[i], upow[n-i])});
            acc_x += basis * 64'(pred_ctrl_x[i]);
            acc_y += basis * 64'(pred_ctrl_y[i]);
        end
        cp.curve_x = round_saturate(acc_x);
        cp.curve_y = round_saturate(acc_y);
        cp.sample_number = pred_counter;
        cp.last_sample = last;
        expected_points.push_back(cp);
        if (last) begin
            pred_param = '0;
            pred_counter = '0;
        end else begin
            nxt = {15'd0, pred_param} + {15'd0, pred_t_step};
            pred_param = (nxt > ONE_Q16) ? 17'(ONE_Q16) : nxt[16:0];
            pred_counter = pred_counter + 1'b1;
        end
    endtask

    // Input driver: one transfer per pending item, with a random gap after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && s_tready) begin
            predict_curve_point(pending_items.pop_front());
            s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= {pending_items[0].point_index, pending_items[0].op,
                                       pending_items[0].point_y, pending_items[0].point_x};
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge aclk) begin
        curve_point_t got, exp_cp;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[73:64], m_tlast};
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected curve point x=%h y=%h n=%0d last=%0d", $time,
                             got.curve_x, got.curve_y, got.sample_number, got.last_sample);
                    failures++;
                end else begin
                    exp_cp = expected_points.pop_front();
                    if (got !== exp_cp) begin
                        $display("%0t: mismatch expected x=%h y=%h n=%0d last=%0d", $time,
                                 exp_cp.curve_x, exp_cp.curve_y, exp_cp.sample_number,
                                 exp_cp.last_sample);
                        $display("%0t:          actual   x=%h y=%h n=%0d last=%0d", $time,
                                 got.curve_x, got.curve_y, got.sample_number, got.last_sample);
                        failures++;
                    end
                end
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end else if (!m_tready) begin
                if (recv_gap > 0) recv_gap <= recv_gap - 1;
                else m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles without any transfer while work is outstanding.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn ||
            (stim_done && pending_items.size() == 0 && expected_points.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("** bezier_curve_sampler_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT:  pred_point_count = value[2:0];
            REG_SAMPLE_COUNT: pred_sample_count = value[10:0];
            REG_T_STEP:       pred_t_step = value;
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [0:0] op, input logic [1:0] idx,
                              input logic [31:0] x, input logic [31:0] y);
        stream_item_t it;
        it.op = op;
        it.point_index = idx;
        it.point_x = x;
        it.point_y = y;
        pending_items.push_back(it);
    endtask

    // Waits for all queued work to drain and then lets the bench settle.
    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_points.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    // Runs one phase: full curve loads, each followed by a run of samples, mixed with random single items.
    task automatic random_phase(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 4; i++) queue_item(OP_LOAD, i[1:0], random_coord(),
                                                        random_coord());
                sent += 4;
                repeat ($urandom_range(1, 12)) begin
                    queue_item(OP_SAMPLE, 2'($urandom), $urandom, $urandom);
                    sent++;
                end
            end else begin
                queue_item(1'($urandom), 2'($urandom), random_coord(), random_coord());
                sent++;
            end
        end
        wait_idle();
    endtask

    initial begin
        failures = 0;
        stim_done = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pred_point_count = 3'd4;
        pred_sample_count = 11'd2;
        pred_t_step = 17'(ONE_Q16);
        for (int i = 0; i < 4; i++) begin
            pred_ctrl_x[i] = '0;
            pred_ctrl_y[i] = '0;
        end
        pred_param = '0;
        pred_counter = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: samples from reset state, extreme points, saturation.
        queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        queue_item(OP_LOAD, 2'd0, 32'h7fffffff, 32'h80000000);
        queue_item(OP_LOAD, 2'd1, 32'h7fffffff, 32'h80000000);
        queue_item(OP_LOAD, 2'd2, 32'h7fffffff, 32'h80000000);
        queue_item(OP_LOAD, 2'd3, 32'h7fffffff, 32'h80000000);
        queue_item(OP_SAMPLE, 2'd3, 32'hffffffff, 32'hffffffff);
        queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        wait_idle();
        write_register(REG_SAMPLE_COUNT, 17'd5);
        write_register(REG_T_STEP, 17'd16384);
        queue_item(OP_LOAD, 2'd0, 32'h00010000, 32'hffff0000);
        queue_item(OP_LOAD, 2'd1, 32'h80000000, 32'h7fffffff);
        queue_item(OP_LOAD, 2'd2, 32'h7fffffff, 32'h80000000);
        queue_item(OP_LOAD, 2'd3, 32'hfffe0000, 32'h00050000);
        repeat (7) queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        wait_idle();
        // Out-of-range count registers and an oversized step.
        write_register(REG_POINT_COUNT, 17'd0);
        write_register(REG_SAMPLE_COUNT, 17'd0);
        write_register(REG_T_STEP, 17'h1ffff);
        repeat (3) queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        wait_idle();
        write_register(REG_POINT_COUNT, 17'd7);
        write_register(REG_SAMPLE_COUNT, 17'h7ff);
        write_register(REG_T_STEP, 17'd0);
        repeat (3) queue_item(OP_SAMPLE, 2'd0, 32'd0, 32'd0);
        wait_idle();

        // Random phases over several settings, extremes among them.
        for (int ph = 0; ph < 10; ph++) begin
            write_register(REG_POINT_COUNT, 17'($urandom_range(0, 7)));
            case (ph % 4)
                0: write_register(REG_SAMPLE_COUNT, 17'd2);
                1: write_register(REG_SAMPLE_COUNT, 17'd1024);
                default: write_register(REG_SAMPLE_COUNT, 17'($urandom_range(0, 12)));
            endcase
            case (ph % 3)
                0: write_register(REG_T_STEP, 17'($urandom));
                1: write_register(REG_T_STEP, 17'($urandom_range(0, 16384)));
                default: write_register(REG_T_STEP, 17'd65536);
            endcase
            // Lowering the sample count mid sweep is covered by leaving the sweep open.
            random_phase(70);
        end
        stim_done = 1'b1;
        repeat (30) @(posedge aclk);
        if (failures == 0) begin
            $display("** bezier_curve_sampler_unit: PASSED **");
        end else begin
            $display("** bezier_curve_sampler_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
